/* src/nearest_palette_color_search_top_macros.svh */
// Assertion macros shared by the nearest palette color search RTL
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define NPCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define NPCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* src/npcs_pkg.sv */
// Package: constants, payload types, controller types and the squared-difference function of the palette search
`timescale 1ns / 1ps

package npcs_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int LEN_W         = 9;
   localparam int ENTRY_W       = 8;
   localparam int COMP_W        = 8;
   localparam int SQ_W          = 2 * COMP_W;
   localparam int DIST_W        = 18;
   localparam int ENT_CMP_W     = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
   localparam int LEN_CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int RGB_W         = 3 * COMP_W;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [ENTRY_W-1:0] entry_index;
      logic [COMP_W-1:0]  red;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  blue;
   } req_payload_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] nearest_index;
      logic [DIST_W-1:0]  min_distance;
      logic               exact_match;
      logic               found;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic write_entry;
      logic load_query;
      logic issue_read;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_query;
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
      logic out_free;
   } stat_type;

   function automatic logic [SQ_W-1:0] diff_sq(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

/* src/npcs_req_if.sv */
// Interface: request channel (palette writes and color queries)
`timescale 1ns / 1ps

interface npcs_req_if import npcs_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/npcs_rsp_if.sv */
// Interface: response channel (nearest color results)
`timescale 1ns / 1ps

interface npcs_rsp_if import npcs_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/npcs_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/npcs_ctrl.sv */
// Controller: sequences palette writes, the query scan and result hand-off
`timescale 1ns / 1ps
`include "nearest_palette_color_search_top_macros.svh"

module npcs_ctrl import npcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid && stat.req_is_query) begin
               state_in = stat.count_zero ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last distance to settle and a free output slot
            if (!stat.pipe_busy && stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready   = 1'b1;
            cmd.write_entry = stat.req_valid && !stat.req_is_query;
            cmd.load_query  = stat.req_valid && stat.req_is_query;
         end
         ST_SCAN: begin
            cmd.issue_read = 1'b1;
         end
         ST_DRAIN: begin
            cmd.load_result = !stat.pipe_busy && stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

   `NPCS_ASSERT(a_scan_holds, (state_ff == ST_SCAN && !stat.scan_last) |=> (state_ff == ST_SCAN), "scan left early")
   `NPCS_ASSERT(a_result_settled, cmd.load_result |-> (!stat.pipe_busy && stat.out_free), "result loaded while busy")
   `NPCS_ASSERT(a_idle_quiet, cmd.req_ready |-> !stat.pipe_busy, "request taken during a scan")

endmodule

/* src/npcs_datapath.sv */
// Datapath: palette memory, distance pipeline, best-entry tracker, result register
`timescale 1ns / 1ps
`include "nearest_palette_color_search_top_macros.svh"

module npcs_datapath import npcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   npcs_req_if.sink           req,
   npcs_rsp_if.source         rsp,
   input  logic               csr_write_enable,
   input  logic [LEN_W-1:0]   csr_write_data,
   input  cmd_type            cmd,
   output stat_type           stat
);

   logic [LEN_W-1:0]  len_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  addr_ff;
   logic [COMP_W-1:0] q_red_ff;
   logic [COMP_W-1:0] q_green_ff;
   logic [COMP_W-1:0] q_blue_ff;

   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [RGB_W-1:0]  rd_data;

   logic              dist_valid_ff;
   logic [ADDR_W-1:0] dist_idx_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;

   logic              have_ff;
   logic [ADDR_W-1:0] best_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic              take_best;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;

   logic              wr_ok;
   logic              wr_en;

   // Palette memory
   assign wr_ok = ENT_CMP_W'(req.payload.entry_index) < ENT_CMP_W'(PALETTE_DEPTH);
   assign wr_en = cmd.write_entry && wr_ok;

   npcs_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req.payload.entry_index)),
      .wr_data ({req.payload.red, req.payload.green, req.payload.blue}),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Length register and scan count (saturated at the palette depth)
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_write_enable) begin
         len_ff <= csr_write_data;
      end
   end

   assign cnt_in = (LEN_CMP_W'(len_ff) > LEN_CMP_W'(PALETTE_DEPTH)) ?
                   CNT_W'(PALETTE_DEPTH) : CNT_W'(len_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         cnt_ff     <= cnt_in;
         addr_ff    <= '0;
         q_red_ff   <= req.payload.red;
         q_green_ff <= req.payload.green;
         q_blue_ff  <= req.payload.blue;
      end else if (cmd.issue_read) begin
         addr_ff <= addr_ff + CNT_W'(1);
      end
   end

   // Read tag follows the registered RAM output
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue_read;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[ADDR_W-1:0];
   end

   // Distance stage
   assign dist_in = DIST_W'(diff_sq(q_red_ff, rd_data[RGB_W-1 -: COMP_W]))
                  + DIST_W'(diff_sq(q_green_ff, rd_data[2*COMP_W-1 -: COMP_W]))
                  + DIST_W'(diff_sq(q_blue_ff, rd_data[COMP_W-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_valid_ff <= 1'b0;
      end else begin
         dist_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      dist_idx_ff <= rd_idx_ff;
   end

   // Best entry: strict less-than keeps the lowest index on ties
   assign take_best = dist_valid_ff && (!have_ff || (dist_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.load_query) begin
         have_ff <= 1'b0;
      end else if (take_best) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= dist_idx_ff;
      end
   end

   // Result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (have_ff) begin
            rsp_data_ff.nearest_index <= ENTRY_W'(best_idx_ff);
            rsp_data_ff.min_distance  <= best_dist_ff;
            rsp_data_ff.exact_match   <= (best_dist_ff == '0);
            rsp_data_ff.found         <= 1'b1;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;
   assign req.ready   = cmd.req_ready;

   assign stat.req_valid    = req.valid;
   assign stat.req_is_query = (req.payload.req_type == REQ_QUERY);
   assign stat.count_zero   = (cnt_in == '0);
   assign stat.scan_last    = ((addr_ff + CNT_W'(1)) == cnt_ff);
   assign stat.pipe_busy    = rd_valid_ff || dist_valid_ff;
   assign stat.out_free     = !rsp_valid_ff || rsp.ready;

   `NPCS_ASSERT(a_dist_sets_have, dist_valid_ff |=> have_ff, "scanned entry not tracked")
   `NPCS_ASSERT(a_exact_found, (rsp_valid_ff && rsp_data_ff.exact_match) |-> rsp_data_ff.found, "exact match without entry")
   `NPCS_ASSERT_ALWAYS(a_reset_clear, reset |=> (!rsp_valid_ff && !rd_valid_ff && !dist_valid_ff), "reset left pipeline busy")

endmodule

/* src/nearest_palette_color_search_top.sv */
// Top level: nearest palette color search by squared Euclidean distance
`timescale 1ns / 1ps
// Usage:
//  - req_ch carries palette writes (req_type 0: entry_index, red, green, blue)
//    and queries (req_type 1: red, green, blue). A write gives no response;
//    writes may follow each other every cycle while no query is in progress.
//  - csr_write_enable/csr_write_data set palette_length, the number of entries
//    a query scans from entry 0; it saturates at the palette depth. Reset: 0.
//  - A query reads the palette memory one entry per cycle through one distance
//    unit. Each entry passes the RAM read register and the distance register
//    into the best-entry tracker; after the last, the result goes to the output
//    register and only then is the next request taken. An empty palette
//    answers with found = 0 and all other fields zero.
//  - rsp_ch holds the result in an output register. A stalled receiver does
//    not block palette writes or the start of the next query scan; the scan
//    result waits until the output register is free.
//  - Reset is synchronous: it empties the pipeline and the output register and
//    clears palette_length. Palette entries are undefined until written.
//  - Ties go to the lowest entry index.

module nearest_palette_color_search_top import npcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   npcs_req_if.sink         req_ch,
   npcs_rsp_if.source       rsp_ch,
   input  logic             csr_write_enable,
   input  logic [LEN_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   npcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   npcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
